[rtl/pwro_pkg.sv]
// Package with the shared types, register indexes and constants of the pixel window rescaler.
package pwro_pkg;

  localparam int PIX_W  = 16;
  localparam int OUT_W  = 8;
  localparam int IDX_W  = 22;
  localparam int SIZE_W = 12;
  localparam int ORI_W  = 2;
  localparam int CIDX_W = 3;
  localparam int CDAT_W = 16;
  localparam int RECIP_W = 32;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 64;

  typedef logic [PIX_W-1:0]   pixel_t;
  typedef logic [OUT_W-1:0]   scaled_t;
  typedef logic [IDX_W-1:0]   index_t;
  typedef logic [SIZE_W-1:0]  size_t;
  typedef logic [ORI_W-1:0]   orient_t;
  typedef logic [CIDX_W-1:0]  cfg_index_t;
  typedef logic [CDAT_W-1:0]  cfg_data_t;
  typedef logic [RECIP_W-1:0] recip_t;

  localparam cfg_index_t REG_WINDOW_LOW  = 3'd0;
  localparam cfg_index_t REG_WINDOW_HIGH = 3'd1;
  localparam cfg_index_t REG_SLOW_SIZE   = 3'd2;
  localparam cfg_index_t REG_FAST_SIZE   = 3'd3;
  localparam cfg_index_t REG_ORIENTATION = 3'd4;

  localparam orient_t ORIENT_AS_IS     = 2'd0;
  localparam orient_t ORIENT_TRANSPOSE = 2'd1;
  localparam orient_t ORIENT_FLIP_FAST = 2'd2;

  localparam pixel_t  WINDOW_LOW_RESET  = 16'd0;
  localparam pixel_t  WINDOW_HIGH_RESET = 16'd65535;
  localparam size_t   SIZE_RESET        = 12'd2048;

  // 255 * 2^24, and its quotient by the reset window span of 65535.
  localparam recip_t  RECIP_DIVIDEND = 32'hFF00_0000;
  localparam recip_t  RECIP_RESET    = 32'd65280;
  localparam int      ROUND_SHIFT    = 24;
  localparam scaled_t SCALED_FULL    = 8'd255;

endpackage

[rtl/pixel_window_rescale_orient.sv]
// Window/level rescaler of 16-bit pixels to 8 bits with oriented destination index.
//
// Raw pixels enter on the in_ stream, one per request, fast dimension first.
// Each accepted pixel yields exactly one result on the out_ stream: the 8-bit
// window-mapped value, its destination index for the selected orientation, the
// running frame minimum and maximum, and out_tlast on the frame's last pixel.
// Registers are written over the cfg_ port, indexed in the order window_low,
// window_high, frame_slow_size, frame_fast_size, orientation.
// Throughput is one pixel per cycle, set by the two-stage pipeline with its
// single 16x32 multiply, unless the receiver, the divider or a cfg_ request
// stalls it. A write of either window register starts a bit-serial reciprocal
// divider; while it runs, in_tready and cfg_ready are low.
// While a configuration request is offered, in_tready is also low.
// A write of either size register restarts the frame position.
// Reset clears the pipeline, restores the register defaults and loads the
// reciprocal of the default window directly, so no divider pass follows reset.
// When the receiver stalls, the output register holds its request and the
// input stage keeps accepting until both stages are full.
module pixel_window_rescale_orient #(
  parameter int MAX_SIDE = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [pwro_pkg::IN_TDATA_W-1:0]  in_tdata,   // [15:0] pixel_in
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [7:0] scaled_pixel, [29:8] dest_index, [45:30] frame_min, [61:46] frame_max
  output logic [pwro_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                          out_tlast,  // frame_last
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pwro_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [pwro_pkg::CDAT_W-1:0]   cfg_data
);
  import pwro_pkg::*;

  localparam int POS_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int CALC_W = (POS_W + SIZE_W + 1 > IDX_W) ? POS_W + SIZE_W + 1 : IDX_W;
  localparam int PROD_W = PIX_W + RECIP_W;
  localparam int CNT_W  = $clog2(RECIP_W);

  pixel_t  win_low_r, win_high_r;
  size_t   slow_size_r, fast_size_r;
  orient_t orient_r;
  recip_t  recip_r;

  logic [POS_W-1:0] slow_pos_r, fast_pos_r;
  pixel_t           run_min_r, run_max_r;

  logic             div_busy_r;
  logic [CNT_W-1:0] div_cnt_r;
  recip_t           div_q_r;
  logic [PIX_W:0]   div_rem_r;

  logic             s1_valid_r;
  pixel_t           s1_diff_r;
  logic             s1_zero_r, s1_full_r, s1_last_r;
  logic [POS_W-1:0] s1_i_r, s1_j_r;
  pixel_t           s1_min_r, s1_max_r;

  logic    out_valid_r, out_last_r;
  scaled_t out_pix_r;
  index_t  out_idx_r;
  pixel_t  out_min_r, out_max_r;

  logic s2_en, s1_en, in_acc, cfg_acc;

  assign s2_en     = !out_valid_r || out_tready;
  assign s1_en     = !s1_valid_r || s2_en;
  assign in_tready = s1_en && !div_busy_r && !cfg_valid;
  assign cfg_ready = !div_busy_r;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;

  function automatic size_t eff_size(input size_t reg_val);
    size_t res;
    if (reg_val == '0) begin
      res = size_t'(1);
    end else if (int'(reg_val) > MAX_SIDE) begin
      res = size_t'(MAX_SIDE);
    end else begin
      res = reg_val;
    end
    return res;
  endfunction

  size_t w_eff, h_eff;
  assign w_eff = eff_size(slow_size_r);
  assign h_eff = eff_size(fast_size_r);

  // Divider: restoring, one quotient bit per cycle.
  logic [PIX_W:0] div_span, div_rem_sh, div_rem_nxt;
  logic           div_ge;

  always_comb begin
    div_span    = {1'b0, win_high_r - win_low_r};
    div_rem_sh  = {div_rem_r[PIX_W-1:0], div_q_r[RECIP_W-1]};
    div_ge      = div_rem_sh >= div_span;
    div_rem_nxt = div_ge ? div_rem_sh - div_span : div_rem_sh;
  end

  // Input stage: position, statistics and window classification.
  pixel_t pix;
  logic   first, fast_end, last_nxt;
  pixel_t min_nxt, max_nxt;
  logic [POS_W-1:0] slow_pos_nxt, fast_pos_nxt;

  always_comb begin
    pix      = in_tdata[PIX_W-1:0];
    first    = (slow_pos_r == '0) && (fast_pos_r == '0);
    fast_end = (CALC_W'(fast_pos_r) + CALC_W'(1)) >= CALC_W'(h_eff);
    last_nxt = fast_end && ((CALC_W'(slow_pos_r) + CALC_W'(1)) >= CALC_W'(w_eff));
    min_nxt  = (first || pix < run_min_r) ? pix : run_min_r;
    max_nxt  = (first || pix > run_max_r) ? pix : run_max_r;
    if (fast_end) begin
      fast_pos_nxt = '0;
      slow_pos_nxt = last_nxt ? '0 : slow_pos_r + POS_W'(1);
    end else begin
      fast_pos_nxt = fast_pos_r + POS_W'(1);
      slow_pos_nxt = slow_pos_r;
    end
  end

  // Output stage: multiply, round, saturate, and the destination index.
  logic [PROD_W-1:0] prod;
  logic [PROD_W-ROUND_SHIFT-1:0] rounded;
  scaled_t           pix_nxt;
  logic [CALC_W-1:0] ci, cj, cw, ch, idx_full;

  always_comb begin
    prod    = PROD_W'(s1_diff_r) * PROD_W'(recip_r) + (PROD_W'(1) << (ROUND_SHIFT - 1));
    rounded = prod[PROD_W-1:ROUND_SHIFT];
    if (s1_zero_r) begin
      pix_nxt = '0;
    end else if (s1_full_r || rounded > (PROD_W-ROUND_SHIFT)'(SCALED_FULL)) begin
      pix_nxt = SCALED_FULL;
    end else begin
      pix_nxt = rounded[OUT_W-1:0];
    end
    ci = CALC_W'(s1_i_r);
    cj = CALC_W'(s1_j_r);
    cw = CALC_W'(w_eff);
    ch = CALC_W'(h_eff);
    case (orient_r)
      ORIENT_TRANSPOSE: idx_full = cj * cw + ci;
      ORIENT_FLIP_FAST: idx_full = ci * ch + (ch - CALC_W'(1) - cj);
      default:          idx_full = ci * ch + cj;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_low_r   <= WINDOW_LOW_RESET;
      win_high_r  <= WINDOW_HIGH_RESET;
      slow_size_r <= SIZE_RESET;
      fast_size_r <= SIZE_RESET;
      orient_r    <= ORIENT_AS_IS;
      recip_r     <= RECIP_RESET;
      slow_pos_r  <= '0;
      fast_pos_r  <= '0;
      run_min_r   <= '0;
      run_max_r   <= '0;
      div_busy_r  <= 1'b0;
      div_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_acc) begin
        case (cfg_index)
          REG_WINDOW_LOW: begin
            win_low_r <= cfg_data[PIX_W-1:0];
            div_busy_r <= 1'b1;
          end
          REG_WINDOW_HIGH: begin
            win_high_r <= cfg_data[PIX_W-1:0];
            div_busy_r <= 1'b1;
          end
          REG_SLOW_SIZE: begin
            slow_size_r <= cfg_data[SIZE_W-1:0];
            slow_pos_r  <= '0;
            fast_pos_r  <= '0;
          end
          REG_FAST_SIZE: begin
            fast_size_r <= cfg_data[SIZE_W-1:0];
            slow_pos_r  <= '0;
            fast_pos_r  <= '0;
          end
          REG_ORIENTATION: orient_r <= cfg_data[ORI_W-1:0];
          default: ;
        endcase
        div_cnt_r <= '0;
      end else if (in_acc) begin
        slow_pos_r <= slow_pos_nxt;
        fast_pos_r <= fast_pos_nxt;
        run_min_r  <= min_nxt;
        run_max_r  <= max_nxt;
      end
      if (div_busy_r) begin
        div_cnt_r <= div_cnt_r + CNT_W'(1);
        if (div_cnt_r == CNT_W'(RECIP_W - 1)) begin
          recip_r    <= {div_q_r[RECIP_W-2:0], div_ge};
          div_busy_r <= 1'b0;
        end
      end
      if (s1_en) begin
        s1_valid_r <= in_acc;
      end
      if (s2_en) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_acc) begin
      div_q_r   <= RECIP_DIVIDEND;
      div_rem_r <= '0;
    end else if (div_busy_r) begin
      div_q_r   <= {div_q_r[RECIP_W-2:0], div_ge};
      div_rem_r <= div_rem_nxt;
    end
    if (in_acc) begin
      s1_diff_r <= pix - win_low_r;
      s1_zero_r <= pix <= win_low_r;
      s1_full_r <= win_high_r <= win_low_r;
      s1_last_r <= last_nxt;
      s1_i_r    <= slow_pos_r;
      s1_j_r    <= fast_pos_r;
      s1_min_r  <= min_nxt;
      s1_max_r  <= max_nxt;
    end
    if (s2_en && s1_valid_r) begin
      out_pix_r  <= pix_nxt;
      out_idx_r  <= idx_full[IDX_W-1:0];
      out_min_r  <= s1_min_r;
      out_max_r  <= s1_max_r;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_TDATA_W'({out_max_r, out_min_r, out_idx_r, out_pix_r});

endmodule

[rtl/pwro_check.sv]
// Port-level checker of the pixel window rescaler and its bind to the top level.
module pwro_check (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pwro_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [pwro_pkg::CIDX_W-1:0]     cfg_index
);
  import pwro_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output request changed");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[45:30] <= out_tdata[61:46])
    else $error("frame minimum above frame maximum");

  a_window_write_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && (cfg_index == REG_WINDOW_LOW || cfg_index == REG_WINDOW_HIGH)
    |=> !in_tready && !cfg_ready)
    else $error("input accepted while reciprocal is formed");

endmodule

bind pixel_window_rescale_orient pwro_check u_pwro_check (.*);
